// ===== hw/rtl/sas_pkg.sv =====
// Shared types, constants and helpers for the sprite animation sequencer.
// Used by the generic RAM user (top level); no dependencies.
package sas_pkg;

  localparam int NUM_NODES  = 16;
  localparam int MAX_FRAMES = 8;
  localparam int MAX_TRANS  = 4;
  localparam int NUM_CONDS  = 16;

  localparam int NODE_W   = $clog2(NUM_NODES);
  localparam int FRAME_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int TRANS_W  = (MAX_TRANS > 1) ? $clog2(MAX_TRANS) : 1;
  localparam int FLEN_DEPTH = NUM_NODES * MAX_FRAMES;
  localparam int TRAN_DEPTH = NUM_NODES * MAX_TRANS;
  localparam int FADDR_W  = $clog2(FLEN_DEPTH);
  localparam int TADDR_W  = $clog2(TRAN_DEPTH);

  localparam int FLAG_STOP = 0;
  localparam int FLAG_PUC  = 1;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_ADDR_W  = 3;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_LOAD_FLEN = 3'd1,
    OP_LOAD_TRAN = 3'd2,
    OP_LOAD_NODE = 3'd3,
    OP_RESTART   = 3'd4
  } op_t;

  localparam logic REG_START_NODE = 1'b0;

  typedef struct packed {
    logic [5:0]  pad;
    logic [15:0] conditions;
    logic [2:0]  node_flags;
    logic [3:0]  frame_count;
    logic        trans_valid;
    logic [3:0]  trans_cond;
    logic [3:0]  trans_target;
    logic [15:0] frame_length;
    logic [2:0]  slot;
    logic [3:0]  node;
    logic [2:0]  op;
  } in_item_t;

  typedef struct packed {
    logic [2:0] pad;
    logic       jumped;
    logic       can_interrupt;
    logic [2:0] flags_out;
    logic       frame_valid;
    logic [2:0] cur_frame;
    logic [3:0] cur_node;
  } out_item_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] cond;
    logic [3:0] target;
  } trans_t;

  typedef struct packed {
    logic [3:0] count;
    logic [2:0] flags;
  } node_info_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FRAME = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  function automatic logic [FRAME_W-1:0] last_frame(input logic [3:0] count);
    logic [FRAME_W-1:0] res;
    if (count == 4'd0) begin
      res = '0;
    end else if (int'(count) > MAX_FRAMES) begin
      res = FRAME_W'(MAX_FRAMES - 1);
    end else begin
      res = FRAME_W'(count - 4'd1);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/sprite_animation_sequencer_unit.sv =====
// Sprite animation sequencer top level: request sequencer, node table and memories.
// Depends on sas_pkg and sas_ram.
//
// Each request is handled alone. Load, restart and unused op codes pass through the
// execute state to the output state. A tick goes from execute straight to the frame
// step when the node may not be interrupted. Otherwise it first scans the transition
// slots and goes to output on a taken transition, or to the frame step when none is
// taken after all four slots are scanned: the transition memory has one read port and
// is walked one slot per cycle. The output register lets the next request be accepted
// while a result still waits. No clearing pass follows reset.
module sprite_animation_sequencer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // tdata: op[2:0], node[6:3], slot[9:7], frame_length[25:10], trans_target[29:26],
  // trans_cond[33:30], trans_valid[34], frame_count[38:35], node_flags[41:39],
  // conditions[57:42], zero fill above.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [sas_pkg::IN_TDATA_W-1:0] in_tdata,
  // tdata: cur_node[3:0], cur_frame[6:4], frame_valid[7], flags_out[10:8],
  // can_interrupt[11], jumped[12], zero fill above.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sas_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [sas_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);

  sas_pkg::state_t   state_r, state_nxt;
  sas_pkg::in_item_t item_r;
  logic [sas_pkg::NODE_W-1:0]  cur_node_r, cur_node_nxt;
  logic [sas_pkg::FRAME_W-1:0] cur_frame_r, cur_frame_nxt;
  logic                        started_r, started_nxt;
  logic [15:0]                 tick_r, tick_nxt;
  logic                        jumped_r, jumped_nxt;
  logic [sas_pkg::TRANS_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [sas_pkg::TRANS_W-1:0] pend_idx_r, pend_idx_nxt;
  logic                        pend_r, pend_nxt;
  logic                        pend_wr_r, pend_wr_nxt;
  logic [sas_pkg::TRAN_DEPTH-1:0] trans_wr_r, trans_wr_nxt;
  logic [3:0]                  start_node_r;
  logic                        out_valid_r;
  sas_pkg::out_item_t          out_data_r;
  sas_pkg::node_info_t         node_info_r [sas_pkg::NUM_NODES];

  logic                         flen_we;
  logic [sas_pkg::FADDR_W-1:0]  flen_waddr, flen_raddr;
  logic [15:0]                  flen_rdata;
  logic                         tran_we;
  logic [sas_pkg::TADDR_W-1:0]  tran_waddr, tran_raddr;
  logic [8:0]                   tran_rdata;
  sas_pkg::trans_t              tran_rd;
  logic                         node_we;

  sas_pkg::node_info_t          cur_info;
  logic [sas_pkg::FRAME_W-1:0]  last_idx;
  logic                         on_last;
  logic                         eligible;
  logic                         hit;
  logic [15:0]                  tick_inc;
  logic                         out_load;
  logic                         cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == sas_pkg::REG_START_NODE);
  assign cfg_prdata = (cfg_paddr[2] == sas_pkg::REG_START_NODE) ? {28'd0, start_node_r} : 32'd0;

  assign in_tready  = (state_r == sas_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cur_info = node_info_r[cur_node_r];
  assign last_idx = sas_pkg::last_frame(cur_info.count);
  assign on_last  = started_r && (cur_frame_r == last_idx);
  assign eligible = !cur_info.flags[sas_pkg::FLAG_PUC] || on_last;
  assign tick_inc = (tick_r == 16'hFFFF) ? tick_r : tick_r + 16'd1;
  assign out_load = (state_r == sas_pkg::S_OUT) && (!out_valid_r || out_tready);

  assign flen_raddr = sas_pkg::FADDR_W'(int'(cur_node_r) * sas_pkg::MAX_FRAMES
                                        + int'(cur_frame_r));
  assign flen_waddr = sas_pkg::FADDR_W'(int'(item_r.node) * sas_pkg::MAX_FRAMES
                                        + int'(item_r.slot));
  assign tran_raddr = sas_pkg::TADDR_W'(int'(cur_node_r) * sas_pkg::MAX_TRANS
                                        + int'(scan_idx_r));
  assign tran_waddr = sas_pkg::TADDR_W'(int'(item_r.node) * sas_pkg::MAX_TRANS
                                        + int'(item_r.slot));
  assign tran_rd    = sas_pkg::trans_t'(tran_rdata);

  assign flen_we = (state_r == sas_pkg::S_EXEC) && (item_r.op == sas_pkg::OP_LOAD_FLEN)
                   && (int'(item_r.node) < sas_pkg::NUM_NODES)
                   && (int'(item_r.slot) < sas_pkg::MAX_FRAMES);
  assign tran_we = (state_r == sas_pkg::S_EXEC) && (item_r.op == sas_pkg::OP_LOAD_TRAN)
                   && (int'(item_r.node) < sas_pkg::NUM_NODES)
                   && (int'(item_r.slot) < sas_pkg::MAX_TRANS);
  assign node_we = (state_r == sas_pkg::S_EXEC) && (item_r.op == sas_pkg::OP_LOAD_NODE)
                   && (int'(item_r.node) < sas_pkg::NUM_NODES);

  assign hit = pend_r && pend_wr_r && tran_rd.valid
               && (int'(tran_rd.cond) < sas_pkg::NUM_CONDS)
               && item_r.conditions[tran_rd.cond];

  sas_ram #(
    .WIDTH (16),
    .DEPTH (sas_pkg::FLEN_DEPTH)
  ) u_flen_ram (
    .clk   (clk),
    .we    (flen_we),
    .waddr (flen_waddr),
    .wdata (item_r.frame_length),
    .raddr (flen_raddr),
    .rdata (flen_rdata)
  );

  sas_ram #(
    .WIDTH (9),
    .DEPTH (sas_pkg::TRAN_DEPTH)
  ) u_tran_ram (
    .clk   (clk),
    .we    (tran_we),
    .waddr (tran_waddr),
    .wdata ({item_r.trans_valid, item_r.trans_cond, item_r.trans_target}),
    .raddr (tran_raddr),
    .rdata (tran_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cur_node_nxt  = cur_node_r;
    cur_frame_nxt = cur_frame_r;
    started_nxt   = started_r;
    tick_nxt      = tick_r;
    jumped_nxt    = jumped_r;
    scan_idx_nxt  = scan_idx_r;
    pend_idx_nxt  = pend_idx_r;
    pend_nxt      = pend_r;
    pend_wr_nxt   = pend_wr_r;
    trans_wr_nxt  = trans_wr_r;
    if (tran_we) begin
      trans_wr_nxt[tran_waddr] = 1'b1;
    end
    case (state_r)
      sas_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt  = sas_pkg::S_EXEC;
          jumped_nxt = 1'b0;
        end
      end
      sas_pkg::S_EXEC: begin
        state_nxt = sas_pkg::S_OUT;
        case (item_r.op)
          sas_pkg::OP_TICK: begin
            scan_idx_nxt = '0;
            pend_nxt     = 1'b0;
            state_nxt    = eligible ? sas_pkg::S_SCAN : sas_pkg::S_FRAME;
          end
          sas_pkg::OP_RESTART: begin
            cur_node_nxt  = sas_pkg::NODE_W'(32'(start_node_r) % sas_pkg::NUM_NODES);
            cur_frame_nxt = '0;
            started_nxt   = 1'b0;
            tick_nxt      = '0;
          end
          default: begin
          end
        endcase
      end
      sas_pkg::S_SCAN: begin
        if (hit) begin
          cur_node_nxt  = sas_pkg::NODE_W'(32'(tran_rd.target) % sas_pkg::NUM_NODES);
          cur_frame_nxt = '0;
          started_nxt   = 1'b1;
          tick_nxt      = '0;
          jumped_nxt    = 1'b1;
          state_nxt     = sas_pkg::S_OUT;
        end else if (pend_r && (int'(pend_idx_r) == sas_pkg::MAX_TRANS - 1)) begin
          state_nxt = sas_pkg::S_FRAME;
        end else begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_idx_r;
          pend_wr_nxt  = trans_wr_r[tran_raddr];
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      sas_pkg::S_FRAME: begin
        state_nxt = sas_pkg::S_OUT;
        if (!(cur_info.flags[sas_pkg::FLAG_STOP] && on_last)) begin
          if (!started_r) begin
            started_nxt   = 1'b1;
            cur_frame_nxt = '0;
            tick_nxt      = '0;
          end else if (tick_inc > flen_rdata) begin
            cur_frame_nxt = (cur_frame_r >= last_idx) ? '0 : cur_frame_r + 1'b1;
            tick_nxt      = '0;
          end else begin
            tick_nxt = tick_inc;
          end
        end
      end
      sas_pkg::S_OUT: begin
        if (out_load) begin
          state_nxt = sas_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sas_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sas_pkg::S_IDLE;
      cur_node_r   <= '0;
      cur_frame_r  <= '0;
      started_r    <= 1'b0;
      tick_r       <= '0;
      jumped_r     <= 1'b0;
      scan_idx_r   <= '0;
      pend_idx_r   <= '0;
      pend_r       <= 1'b0;
      pend_wr_r    <= 1'b0;
      trans_wr_r   <= '0;
      start_node_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_node_r  <= cur_node_nxt;
      cur_frame_r <= cur_frame_nxt;
      started_r   <= started_nxt;
      tick_r      <= tick_nxt;
      jumped_r    <= jumped_nxt;
      scan_idx_r  <= scan_idx_nxt;
      pend_idx_r  <= pend_idx_nxt;
      pend_r      <= pend_nxt;
      pend_wr_r   <= pend_wr_nxt;
      trans_wr_r  <= trans_wr_nxt;
      if (cfg_wr) begin
        start_node_r <= cfg_pwdata[3:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= sas_pkg::in_item_t'(in_tdata);
    end
    if (node_we) begin
      node_info_r[item_r.node] <= '{count: item_r.frame_count, flags: item_r.node_flags};
    end
    if (out_load) begin
      out_data_r.pad           <= '0;
      out_data_r.jumped        <= jumped_r;
      out_data_r.can_interrupt <= !cur_info.flags[sas_pkg::FLAG_PUC];
      out_data_r.flags_out     <= cur_info.flags;
      out_data_r.frame_valid   <= started_r;
      out_data_r.cur_frame     <= started_r ? 3'(cur_frame_r) : 3'd0;
      out_data_r.cur_node      <= 4'(cur_node_r);
    end
  end

endmodule

// ===== hw/rtl/sas_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
